// File: rtl/core/udr_pkg.sv
package udr_pkg;

  localparam int PI_Q13       = 25736;
  localparam int HALF_PI_Q13  = 12868;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

  // atan(2^-i) in Q2.29
  function automatic logic signed [33:0] atan_lut(input int i);
    logic signed [33:0] t;
    case (i)
      0: t = 34'sd421657428;
      1: t = 34'sd248918915;
      2: t = 34'sd131521918;
      3: t = 34'sd66762579;
      4: t = 34'sd33510843;
      5: t = 34'sd16771758;
      6: t = 34'sd8387925;
      7: t = 34'sd4194219;
      8: t = 34'sd2097141;
      9: t = 34'sd1048575;
      default: t = 34'sd1 <<< (29 - i);
    endcase
    return t;
  endfunction

  // front to back: one classified transaction
  typedef struct packed {
    logic signed [31:0] pn;
    logic signed [31:0] pe;
    logic signed [15:0] v;
    logic signed [15:0] h0;
    logic        [15:0] p;
    logic signed [31:0] pr;
  } udr_item_t;

endpackage

// File: rtl/core/udr_front.sv
// Front: captures a transaction and forms period * yaw_rate.
module udr_front import udr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic signed [31:0] pn,
  input  logic signed [31:0] pe,
  input  logic signed [15:0] v,
  input  logic signed [15:0] h,
  input  logic signed [15:0] r,
  input  logic        [15:0] p,
  output logic               vld_r,
  output udr_item_t          item_r
);
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= acc;
    item_r.pn <= pn;
    item_r.pe <= pe;
    item_r.v  <= v;
    item_r.h0 <= h;
    item_r.p  <= p;
    item_r.pr <= 32'($signed({1'b0, p})) * 32'(r);
  end
endmodule

// File: rtl/core/udr_cordic.sv
// Pipelined rotation CORDIC: one stage per register, quadrant fold up front.
module udr_cordic import udr_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic signed [16:0] ang,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);
  logic signed [33:0] x_r [STAGES+1];
  logic signed [33:0] y_r [STAGES+1];
  logic signed [33:0] z_r [STAGES+1];
  logic               f_r [STAGES+1];
  logic signed [17:0] aw, af;
  logic               fl;

  // wrap then fold into [-pi/2, pi/2]
  always_comb begin
    aw = 18'(ang);
    if (aw >= 18'(PI_Q13)) aw = aw - 18'(2 * PI_Q13);
    else if (aw < -18'(PI_Q13)) aw = aw + 18'(2 * PI_Q13);
    fl = 1'b0;
    af = aw;
    if (aw > 18'(HALF_PI_Q13)) begin
      af = aw - 18'(PI_Q13); fl = 1'b1;
    end else if (aw < -18'(HALF_PI_Q13)) begin
      af = aw + 18'(PI_Q13); fl = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= INV_GAIN;
    y_r[0] <= '0;
    z_r[0] <= 34'(af) <<< 16;
    f_r[0] <= fl;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    always_ff @(posedge clk) begin
      f_r[i+1] <= f_r[i];
      if (!z_r[i][33]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_lut(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_lut(i);
      end
    end
  end

  function automatic logic signed [15:0] fin(input logic signed [33:0] a, input logic f);
    logic signed [34:0] t;
    logic signed [19:0] q;
    t = 35'(a) + 35'sd16384;
    q = 20'(t >>> 15);
    if (q > 20'sd32767) q = 20'sd32767;
    else if (q < -20'sd32768) q = -20'sd32768;
    if (f) q = -q;
    if (q > 20'sd32767) q = 20'sd32767;
    return q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    cos_o <= fin(x_r[STAGES], f_r[STAGES]);
    sin_o <= fin(y_r[STAGES], f_r[STAGES]);
  end
endmodule

// File: rtl/core/udr_back.sv
// Back: new heading, two CORDICs, products, rounding and saturation.
module udr_back import udr_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld,
  input  udr_item_t          item,
  output logic               out_vld,
  output logic signed [31:0] next_north,
  output logic signed [31:0] next_east,
  output logic signed [15:0] next_heading,
  output logic signed [15:0] jac_north_speed,
  output logic signed [31:0] jac_north_heading,
  output logic signed [15:0] jac_east_speed,
  output logic signed [31:0] jac_east_heading
);
  localparam int LAT = STAGES + 2;
  localparam int D = LAT;

  logic signed [17:0] nh_sum;
  logic signed [16:0] nh_w;
  logic signed [16:0] nh_r;
  udr_item_t          it_r;
  logic               v_r;

  always_comb begin
    nh_sum = 18'(item.h0) + 18'((34'(item.pr) + 34'sd32768) >>> 16);
    if (nh_sum >= 18'(PI_Q13)) nh_sum = nh_sum - 18'(2 * PI_Q13);
    else if (nh_sum < -18'(PI_Q13)) nh_sum = nh_sum + 18'(2 * PI_Q13);
    nh_w = 17'(nh_sum);
  end

  // heading step wrap needs two passes at most: second pass on register
  logic signed [17:0] nh2;
  always_comb begin
    nh2 = 18'(nh_r);
    if (nh2 >= 18'(PI_Q13)) nh2 = nh2 - 18'(2 * PI_Q13);
    else if (nh2 < -18'(PI_Q13)) nh2 = nh2 + 18'(2 * PI_Q13);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= vld;
    nh_r <= nh_w;
    it_r <= item;
  end

  logic signed [15:0] c0, s0, c1, s1;
  udr_cordic #(.STAGES(STAGES)) u_c0 (.clk(clk), .ang(17'(it_r.h0)), .cos_o(c0), .sin_o(s0));
  udr_cordic #(.STAGES(STAGES)) u_c1 (.clk(clk), .ang(17'(nh2)), .cos_o(c1), .sin_o(s1));

  // delay line for the side data, matched to CORDIC latency
  udr_item_t          dl_it [D];
  logic signed [15:0] dl_nh [D];
  logic               dl_v  [D];
  always_ff @(posedge clk) begin
    dl_it[0] <= it_r;
    dl_nh[0] <= 16'(nh2);
    if (!rst_n) dl_v[0] <= 1'b0;
    else dl_v[0] <= v_r;
  end
  for (genvar k = 1; k < D; k++) begin : g_dl
    always_ff @(posedge clk) begin
      dl_it[k] <= dl_it[k-1];
      dl_nh[k] <= dl_nh[k-1];
      if (!rst_n) dl_v[k] <= 1'b0;
      else dl_v[k] <= dl_v[k-1];
    end
  end

  // P*V registered alongside, then products with trig
  logic signed [32:0] pv_r;
  always_ff @(posedge clk)
    pv_r <= 33'($signed({1'b0, dl_it[LAT-2].p})) * 33'(dl_it[LAT-2].v);

  udr_item_t          i2;
  logic signed [15:0] h2;
  logic               v2;
  logic signed [48:0] m_nc, m_es, m_jnh, m_jeh;
  logic signed [32:0] m_pc, m_ps;
  always_ff @(posedge clk) begin
    m_nc  <= 49'(pv_r) * 49'(c0);
    m_es  <= 49'(pv_r) * 49'(s0);
    m_jnh <= -(49'(pv_r) * 49'(s1));
    m_jeh <= 49'(pv_r) * 49'(c1);
    m_pc  <= 33'($signed({1'b0, dl_it[LAT-1].p})) * 33'(c1);
    m_ps  <= 33'($signed({1'b0, dl_it[LAT-1].p})) * 33'(s1);
    i2 <= dl_it[LAT-1];
    h2 <= dl_nh[LAT-1];
    if (!rst_n) v2 <= 1'b0;
    else v2 <= dl_v[LAT-1];
  end

  function automatic logic signed [31:0] sat32(input logic signed [50:0] a);
    if (a > 51'sd2147483647) return 32'sh7fffffff;
    if (a < -51'sd2147483648) return 32'sh80000000;
    return a[31:0];
  endfunction
  function automatic logic signed [15:0] sat16(input logic signed [33:0] a);
    logic signed [33:0] q;
    q = (a + 34'sd32768) >>> 16;
    if (q > 34'sd32767) return 16'sh7fff;
    if (q < -34'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction
  function automatic logic signed [50:0] r23(input logic signed [48:0] a);
    return 51'((50'(a) + 50'sd4194304) >>> 23);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld <= 1'b0;
    else out_vld <= v2;
    next_north        <= sat32(51'(i2.pn) + r23(m_nc));
    next_east         <= sat32(51'(i2.pe) + r23(m_es));
    next_heading      <= h2;
    jac_north_speed   <= sat16(34'(m_pc));
    jac_east_speed    <= sat16(34'(m_ps));
    jac_north_heading <= sat32(r23(m_jnh));
    jac_east_heading  <= sat32(r23(m_jeh));
  end
endmodule

// File: rtl/core/unicycle_dead_reckoning_step.sv
// Channel   Handshake          Payload
// in_       start / busy       pos_north pos_east speed heading yaw_rate
// out_      out_valid strobe   next_* and jac_* fields
// cfg_      cfg_we             cfg_data (sample period)
// One transaction accepted per cycle; busy is held low.
// out_valid rises after the front register, the CORDIC pipeline and the product and
// output registers; the CORDIC pipeline depth sets the delay.
// rst_n is synchronous; it clears valid flags and loads the period 6554.
// The receiver cannot stall: each result shows for one cycle only.
module unicycle_dead_reckoning_step import udr_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_north,
  input  logic signed [31:0] in_pos_east,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_heading,
  input  logic signed [15:0] in_yaw_rate,
  input  logic               cfg_we,
  input  logic        [15:0] cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_next_north,
  output logic signed [31:0] out_next_east,
  output logic signed [15:0] out_next_heading,
  output logic signed [15:0] out_jac_north_speed,
  output logic signed [31:0] out_jac_north_heading,
  output logic signed [15:0] out_jac_east_speed,
  output logic signed [31:0] out_jac_east_heading
);
  logic [15:0] period_r;
  logic        fv;
  udr_item_t   fi;

  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= 16'd6554;
    else if (cfg_we) period_r <= cfg_data;
  end

  assign busy = 1'b0;

  udr_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(start), .pn(in_pos_north), .pe(in_pos_east),
    .v(in_speed), .h(in_heading), .r(in_yaw_rate), .p(period_r),
    .vld_r(fv), .item_r(fi)
  );

  udr_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n), .vld(fv), .item(fi), .out_vld(out_valid),
    .next_north(out_next_north), .next_east(out_next_east),
    .next_heading(out_next_heading), .jac_north_speed(out_jac_north_speed),
    .jac_north_heading(out_jac_north_heading), .jac_east_speed(out_jac_east_speed),
    .jac_east_heading(out_jac_east_heading)
  );

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_heading >= -16'sd25736 && out_next_heading <= 16'sd25735))
    else $error("heading out of range");
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> fv) else $error("front lost a transaction");
endmodule

// File: tb/sv/tb_unicycle_dead_reckoning_step.sv
module tb_unicycle_dead_reckoning_step import udr_pkg::*;;

  localparam int  STAGES   = 16;
  localparam int  LATENCY  = STAGES + 7;
  localparam int  N_DIR    = 14;
  localparam int  LIMIT    = 400000;
  localparam longint TWO_PI = 2 * PI_Q13;

  // one predicted result
  typedef struct {
    logic signed [31:0] nn;
    logic signed [31:0] ne;
    logic signed [15:0] nh;
    logic signed [15:0] jns;
    logic signed [31:0] jnh;
    logic signed [15:0] jes;
    logic signed [31:0] jeh;
  } pose_t;

  // one directed row: period, inputs, optional typed expectation
  typedef struct {
    logic        [15:0] per;
    logic signed [31:0] pn;
    logic signed [31:0] pe;
    logic signed [15:0] v;
    logic signed [15:0] h;
    logic signed [15:0] r;
    bit                 typed;
    pose_t              res;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_pos_north = '0;
  logic signed [31:0] in_pos_east = '0;
  logic signed [15:0] in_speed = '0;
  logic signed [15:0] in_heading = '0;
  logic signed [15:0] in_yaw_rate = '0;
  logic               cfg_we = 1'b0;
  logic        [15:0] cfg_data = '0;
  logic               out_valid;
  logic signed [31:0] out_next_north;
  logic signed [31:0] out_next_east;
  logic signed [15:0] out_next_heading;
  logic signed [15:0] out_jac_north_speed;
  logic signed [31:0] out_jac_north_heading;
  logic signed [15:0] out_jac_east_speed;
  logic signed [31:0] out_jac_east_heading;

  pose_t   pose_q[$];
  int      n_err = 0;
  int      cycles = 0;
  longint  period_now = 6554;
  row_t    dir[N_DIR];
  longint  atan_q29[ATAN_ENTRIES] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                            16771758, 8387925, 4194219, 2097141, 1048575, 524288,
                            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
                            1024, 512, 256, 128, 64};

  unicycle_dead_reckoning_step #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_north(in_pos_north), .in_pos_east(in_pos_east), .in_speed(in_speed),
    .in_heading(in_heading), .in_yaw_rate(in_yaw_rate),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_next_north(out_next_north),
    .out_next_east(out_next_east), .out_next_heading(out_next_heading),
    .out_jac_north_speed(out_jac_north_speed),
    .out_jac_north_heading(out_jac_north_heading),
    .out_jac_east_speed(out_jac_east_speed),
    .out_jac_east_heading(out_jac_east_heading)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_unicycle_dead_reckoning_step: FAIL");
      $finish;
    end
  end

  function automatic longint rshr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_pi(longint a);
    while (a >= PI_Q13) a -= TWO_PI;
    while (a < -PI_Q13) a += TWO_PI;
    return a;
  endfunction

  // CORDIC rotation, cos and sin in Q1.15
  function automatic void rot_sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    x = INV_GAIN;
    y = 0;
    flip = 0;
    ang = wrap_pi(ang);
    if (ang > HALF_PI_Q13) begin
      ang -= PI_Q13;
      flip = 1;
    end else if (ang < -HALF_PI_Q13) begin
      ang += PI_Q13;
      flip = 1;
    end
    z = ang * 65536;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q29[i];
      end else begin
        x += dx; y -= dy; z += atan_q29[i];
      end
    end
    x = clip(rshr(x, 15), -32768, 32767);
    y = clip(rshr(y, 15), -32768, 32767);
    if (flip) begin
      x = clip(-x, -32768, 32767);
      y = clip(-y, -32768, 32767);
    end
    c = x;
    s = y;
  endfunction

  function automatic pose_t predict_pose(longint per, longint pn, longint pe,
                                         longint v, longint h, longint r);
    pose_t  o;
    longint pv, c0, s0, c1, s1, nh;
    pv = per * v;
    rot_sincos(h, c0, s0);
    nh = wrap_pi(h + rshr(per * r, 16));
    rot_sincos(nh, c1, s1);
    o.nn  = 32'(clip(pn + rshr(pv * c0, 23), -64'sd2147483648, 64'sd2147483647));
    o.ne  = 32'(clip(pe + rshr(pv * s0, 23), -64'sd2147483648, 64'sd2147483647));
    o.nh  = 16'(nh);
    o.jns = 16'(clip(rshr(per * c1, 16), -32768, 32767));
    o.jnh = 32'(clip(rshr(-(pv * s1), 23), -64'sd2147483648, 64'sd2147483647));
    o.jes = 16'(clip(rshr(per * s1, 16), -32768, 32767));
    o.jeh = 32'(clip(rshr(pv * c1, 23), -64'sd2147483648, 64'sd2147483647));
    return o;
  endfunction

  task automatic report_mismatch(string fld, longint got, longint want);
    n_err++;
    $display("mismatch %s: got %0d, expected %0d at cycle %0d", fld, got, want, cycles);
  endtask

  // result checker
  always @(posedge clk) begin
    pose_t w;
    if (rst_n && out_valid) begin
      if (pose_q.size() == 0) begin
        report_mismatch("unexpected result", out_next_north, 0);
      end else begin
        w = pose_q.pop_front();
        if (out_next_north !== w.nn) report_mismatch("next_north", out_next_north, w.nn);
        if (out_next_east !== w.ne) report_mismatch("next_east", out_next_east, w.ne);
        if (out_next_heading !== w.nh)
          report_mismatch("next_heading", out_next_heading, w.nh);
        if (out_jac_north_speed !== w.jns)
          report_mismatch("jac_north_speed", out_jac_north_speed, w.jns);
        if (out_jac_north_heading !== w.jnh)
          report_mismatch("jac_north_heading", out_jac_north_heading, w.jnh);
        if (out_jac_east_speed !== w.jes)
          report_mismatch("jac_east_speed", out_jac_east_speed, w.jes);
        if (out_jac_east_heading !== w.jeh)
          report_mismatch("jac_east_heading", out_jac_east_heading, w.jeh);
      end
    end
  end

  // stop sending, wait for the pipeline to empty, then write the period
  task automatic set_period(logic [15:0] val);
    start <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_now = val;
  endtask

  // drive one transaction, queue its expectation, then idle for a drawn gap
  task automatic send_pose(logic signed [31:0] pn, logic signed [31:0] pe,
                           logic signed [15:0] v, logic signed [15:0] h,
                           logic signed [15:0] r, bit typed, pose_t res, bit idle);
    int gap;
    start        <= 1'b1;
    in_pos_north <= pn;
    in_pos_east  <= pe;
    in_speed     <= v;
    in_heading   <= h;
    in_yaw_rate  <= r;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (typed) pose_q.push_back(res);
    else pose_q.push_back(predict_pose(period_now, pn, pe, v, h, r));
    gap = idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    pose_t  none;
    pose_t  z1;
    pose_t  z2;
    logic signed [31:0] pn, pe;
    logic signed [15:0] h;
    logic        [15:0] per;
    none = '{0, 0, 0, 0, 0, 0, 0};
    // zero period: nothing moves, heading only wrapped, Jacobians zero
    z1 = '{32'sd5, -32'sd7, 16'sd1000, 0, 0, 0, 0};
    z2 = '{32'sh7fffffff, 32'sh80000000, -16'sd21472, 0, 0, 0, 0};
    dir[0]  = '{16'd6554, 0, 0, 256, 0, 0, 0, none};
    dir[1]  = '{16'd6554, 100, -100, 2560, 25735, 32767, 0, none};
    dir[2]  = '{16'd6554, -1, 1, -2560, -25736, -32768, 0, none};
    dir[3]  = '{16'd6554, 0, 0, 32767, 12868, 0, 0, none};
    dir[4]  = '{16'd6554, 0, 0, 32767, -12868, 1, 0, none};
    dir[5]  = '{16'd6554, 0, 0, 32767, 12869, -1, 0, none};
    dir[6]  = '{16'd0, 5, -7, 1000, 1000, 5000, 1, z1};
    dir[7]  = '{16'd0, 32'sh7fffffff, 32'sh80000000, -32768, 30000, 32767, 1, z2};
    dir[8]  = '{16'd65535, 32'sh7fffffff, 0, 32767, 0, 0, 0, none};
    dir[9]  = '{16'd65535, 32'sh80000000, 0, 32767, 25735, 0, 0, none};
    dir[10] = '{16'd65535, 0, 32'sh7fffffff, 32767, 12868, 32767, 0, none};
    dir[11] = '{16'd65535, 0, 32'sh80000000, -32768, -32768, 32767, 0, none};
    dir[12] = '{16'd65535, -5, 5, -32768, 32767, -32768, 0, none};
    dir[13] = '{16'd1, 12345, -54321, -32768, 6434, 32767, 0, none};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; reset value of the period checked by rows at 6554
    for (int i = 0; i < N_DIR; i++) begin
      if (dir[i].per != period_now) set_period(dir[i].per);
      send_pose(dir[i].pn, dir[i].pe, dir[i].v, dir[i].h, dir[i].r,
                dir[i].typed, dir[i].res, 1'b1);
    end
    start <= 1'b0;

    // random phases over several periods; phase 2 runs back to back
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: per = 16'd1;
        1: per = 16'd65535;
        2: per = 16'd6554;
        3: per = 16'd0;
        default: per = 16'($urandom);
      endcase
      set_period(per);
      for (int k = 0; k < 160; k++) begin
        pn = $urandom;
        pe = $urandom;
        if ($urandom_range(0, 7) == 0) pn = {pn[31], {7{~pn[31]}}, pn[23:0]};
        if ($urandom_range(0, 7) == 0) pe = {pe[31], {7{~pe[31]}}, pe[23:0]};
        if ($urandom_range(0, 9) == 0) h = 16'($urandom);
        else h = 16'($urandom_range(0, 51471) - 25736);
        send_pose(pn, pe, 16'($urandom), h, 16'($urandom), 1'b0, none, ph != 2);
      end
      start <= 1'b0;
    end

    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (n_err == 0 && pose_q.size() == 0) begin
      $display("tb_unicycle_dead_reckoning_step: PASS");
    end else begin
      $display("tb_unicycle_dead_reckoning_step: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/udr_pkg.sv
rtl/core/udr_front.sv
rtl/core/udr_cordic.sv
rtl/core/udr_back.sv
rtl/core/unicycle_dead_reckoning_step.sv
tb/sv/tb_unicycle_dead_reckoning_step.sv
